@@ rtl/sbd_pkg.sv @@
// Shared constants, register codes and interface types of the serial-bus frame decoder.
package sbd_pkg;

   // Frame layout
   localparam logic [7:0] START_MARK    = 8'h0F;
   localparam logic [4:0] FRAME_LENGTH  = 5'd25;
   localparam logic [4:0] END_POSITION  = FRAME_LENGTH - 5'd1;
   localparam int         STORED_BYTES  = 23;                 // bytes 1 to 23 of a frame
   localparam int         FRAME_BITS    = 8 * STORED_BYTES;
   localparam int         RAW_BITS      = 11;
   localparam int         PROP_BITS     = 16 * RAW_BITS;

   // Channel counts
   localparam logic [4:0] MAX_CHANNELS  = 5'd18;
   localparam logic [4:0] PROP_CHANNELS = 5'd16;
   localparam int         TRIM_BITS     = 8 * 18;

   // Frame queue
   localparam int         QUEUE_DEPTH    = 2;
   localparam int         QUEUE_PTR_BITS = 1;
   localparam int         QUEUE_CNT_BITS = 2;

   // Divider: quotient magnitude width
   localparam int         QUOT_BITS = 25;

   // Register indexes (byte address bits [5:3])
   typedef enum logic [2:0] {
      REG_TRIM_LOW  = 3'd0,
      REG_TRIM_MID  = 3'd1,
      REG_TRIM_HIGH = 3'd2,
      REG_IN_MIN    = 3'd3,
      REG_IN_MAX    = 3'd4,
      REG_OUT_MIN   = 3'd5,
      REG_OUT_MAX   = 3'd6,
      REG_CH_USED   = 3'd7
   } reg_index_type;

   // Register reset values
   localparam logic [11:0] IN_MIN_RESET  = 12'd1000;
   localparam logic [11:0] IN_MAX_RESET  = 12'd2000;
   localparam logic [11:0] OUT_MIN_RESET = 12'd1000;
   localparam logic [11:0] OUT_MAX_RESET = 12'd2000;
   localparam logic [4:0]  CH_USED_RESET = 5'd18;

   // Mapping configuration seen by the back end
   typedef struct packed {
      logic [TRIM_BITS-1:0] trims;     // channel 0 trim in the low byte
      logic [11:0]          in_min;
      logic [11:0]          in_max;
      logic [11:0]          out_min;
      logic [11:0]          out_max;
      logic [4:0]           ch_used;
   } cfg_type;

   // Queue status toward both ends
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

@@ rtl/sbd_front.sv @@
// Byte collector: hunts for the start byte and assembles frames for the queue.
module sbd_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // [7:0] rx_byte
   input  sbd_pkg::queue_status_type      q_status,
   output logic                           push,
   output logic [sbd_pkg::FRAME_BITS-1:0] frame
);

   logic [4:0]                     pos_ff, pos_in;
   logic [sbd_pkg::FRAME_BITS-1:0] data_ff, data_in;
   logic                           take;

   // Stall only on the end byte when the queue has no room
   assign req_tready = !q_status.full || (pos_ff != sbd_pkg::END_POSITION);
   assign take       = req_tvalid && req_tready;
   assign push       = take && (pos_ff == sbd_pkg::END_POSITION);
   assign frame      = data_ff;

   // Advance position, shift payload bytes in from the top
   always_comb begin
      pos_in  = pos_ff;
      data_in = data_ff;
      if (take) begin
         if (pos_ff == 5'd0) begin
            if (req_tdata == sbd_pkg::START_MARK) begin
               pos_in = 5'd1;
            end
         end else if (pos_ff == sbd_pkg::END_POSITION) begin
            pos_in = 5'd0;
         end else begin
            data_in = {req_tdata, data_ff[sbd_pkg::FRAME_BITS-1:8]};
            pos_in  = pos_ff + 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 5'd0;
      end else begin
         pos_ff <= pos_in;
      end
      data_ff <= data_in;
   end

`ifndef SYNTHESIS
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= sbd_pkg::END_POSITION)
      else $error("frame position out of range");
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full)
      else $error("frame pushed into a full queue");
`endif

endmodule

@@ rtl/sbd_queue.sv @@
// Two-entry frame queue between the collector and the mapper.
module sbd_queue (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  logic [sbd_pkg::FRAME_BITS-1:0] wr_frame,
   input  logic                           pop,
   output logic [sbd_pkg::FRAME_BITS-1:0] rd_frame,
   output sbd_pkg::queue_status_type      status
);

   logic [sbd_pkg::FRAME_BITS-1:0]     mem_ff [sbd_pkg::QUEUE_DEPTH];
   logic [sbd_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [sbd_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [sbd_pkg::QUEUE_CNT_BITS-1:0] cnt_ff, cnt_in;

   assign status.full  = (cnt_ff == sbd_pkg::QUEUE_CNT_BITS'(sbd_pkg::QUEUE_DEPTH));
   assign status.empty = (cnt_ff == '0);
   assign rd_frame     = mem_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + sbd_pkg::QUEUE_CNT_BITS'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - sbd_pkg::QUEUE_CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Store frames
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_frame;
      end
   end

`ifndef SYNTHESIS
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("pop from an empty frame queue");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= sbd_pkg::QUEUE_CNT_BITS'(sbd_pkg::QUEUE_DEPTH))
      else $error("frame queue occupancy out of range");
`endif

endmodule

@@ rtl/sbd_back.sv @@
// Channel mapper: unpacks a queued frame, trims and remaps each channel through a serial divider.
module sbd_back (
   input  logic                           clock,
   input  logic                           reset,
   input  sbd_pkg::cfg_type               cfg,
   input  sbd_pkg::queue_status_type      q_status,
   input  logic [sbd_pkg::FRAME_BITS-1:0] q_frame,
   output logic                           pop,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [23:0]                    rsp_tdata,   // [4:0] channel_index, [20:5] channel_value
   output logic                           rsp_tlast    // last_channel
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_MULT,
      ST_DIV,
      ST_FIN
   } state_type;

   state_type                       state_ff, state_in;
   logic [sbd_pkg::PROP_BITS-1:0]   chan_ff, chan_in;
   logic [1:0]                      dig_ff, dig_in;
   logic [sbd_pkg::TRIM_BITS-1:0]   trim_ff, trim_in;
   logic [4:0]                      ch_ff, ch_in;
   logic [4:0]                      count_ff, count_in;
   logic [12:0]                     maga_ff, maga_in;
   logic [11:0]                     magb_ff, magb_in;
   logic                            neg_ff, neg_in;
   logic [sbd_pkg::QUOT_BITS-1:0]   quot_ff, quot_in;
   logic [12:0]                     rem_ff, rem_in;
   logic [4:0]                      step_ff, step_in;
   logic                            out_valid_ff, out_valid_in;
   logic [4:0]                      out_index_ff, out_index_in;
   logic [15:0]                     out_value_ff, out_value_in;
   logic                            out_last_ff, out_last_in;

   logic [4:0]  sat_count;
   logic [11:0] raw;
   logic [13:0] x_val;
   logic [13:0] a_val;
   logic [13:0] a_abs;
   logic [12:0] b_val;
   logic [12:0] b_abs;
   logic [12:0] d_val;
   logic [12:0] d_abs;
   logic [12:0] trial;
   logic        fits;
   logic [15:0] q_low;
   logic [15:0] q_signed;
   logic [15:0] y_val;
   logic        out_free;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_value_ff, out_index_ff};
   assign rsp_tlast  = out_last_ff;
   assign out_free   = !out_valid_ff || rsp_tready;
   assign pop        = (state_ff == ST_IDLE) && !q_status.empty;

   // Channel count clamped to the supported maximum
   assign sat_count = (cfg.ch_used > sbd_pkg::MAX_CHANNELS) ? sbd_pkg::MAX_CHANNELS
                                                            : cfg.ch_used;

   // Trimmed input and map operands of the current channel
   always_comb begin
      if (ch_ff < sbd_pkg::PROP_CHANNELS) begin
         raw = {1'b0, chan_ff[sbd_pkg::RAW_BITS-1:0]};
      end else begin
         raw = dig_ff[0] ? cfg.in_max : cfg.in_min;
      end
      x_val = {2'b00, raw} + {{6{trim_ff[7]}}, trim_ff[7:0]};
      a_val = x_val - {2'b00, cfg.in_min};
      a_abs = a_val[13] ? (14'd0 - a_val) : a_val;
      b_val = {1'b0, cfg.out_max} - {1'b0, cfg.out_min};
      b_abs = b_val[12] ? (13'd0 - b_val) : b_val;
      d_val = {1'b0, cfg.in_max} - {1'b0, cfg.in_min};
      d_abs = d_val[12] ? (13'd0 - d_val) : d_val;
   end

   // One restoring-division step and the final sign and offset
   always_comb begin
      trial    = {rem_ff[11:0], quot_ff[sbd_pkg::QUOT_BITS-1]};
      fits     = (trial >= {1'b0, d_abs[11:0]});
      q_low    = quot_ff[15:0];
      q_signed = neg_ff ? (16'd0 - q_low) : q_low;
      if (cfg.in_max == cfg.in_min) begin
         y_val = {4'h0, cfg.out_min};
      end else begin
         y_val = q_signed + {4'h0, cfg.out_min};
      end
   end

   // Sequencer next state
   always_comb begin
      state_in     = state_ff;
      chan_in      = chan_ff;
      dig_in       = dig_ff;
      trim_in      = trim_ff;
      ch_in        = ch_ff;
      count_in     = count_ff;
      maga_in      = maga_ff;
      magb_in      = magb_ff;
      neg_in       = neg_ff;
      quot_in      = quot_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_index_in = out_index_ff;
      out_value_in = out_value_ff;
      out_last_in  = out_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               chan_in  = q_frame[sbd_pkg::PROP_BITS-1:0];
               dig_in   = q_frame[sbd_pkg::PROP_BITS+1:sbd_pkg::PROP_BITS];
               trim_in  = cfg.trims;
               count_in = sat_count;
               ch_in    = 5'd0;
               if (sat_count != 5'd0) begin
                  state_in = ST_PREP;
               end
            end
         end
         ST_PREP: begin
            if (ch_ff < sbd_pkg::PROP_CHANNELS) begin
               chan_in = chan_ff >> sbd_pkg::RAW_BITS;
            end else begin
               dig_in = dig_ff >> 1;
            end
            trim_in  = trim_ff >> 8;
            maga_in  = a_abs[12:0];
            magb_in  = b_abs[11:0];
            neg_in   = a_val[13] ^ b_val[12] ^ d_val[12];
            state_in = ST_MULT;
         end
         ST_MULT: begin
            quot_in  = sbd_pkg::QUOT_BITS'(maga_ff) * sbd_pkg::QUOT_BITS'(magb_ff);
            rem_in   = 13'd0;
            step_in  = 5'd0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in  = fits ? (trial - {1'b0, d_abs[11:0]}) : trial;
            quot_in = {quot_ff[sbd_pkg::QUOT_BITS-2:0], fits};
            step_in = step_ff + 5'd1;
            if (step_ff == 5'(sbd_pkg::QUOT_BITS - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            // Hold until the output register frees up
            if (out_free) begin
               out_valid_in = 1'b1;
               out_index_in = ch_ff;
               out_value_in = y_val;
               out_last_in  = (ch_ff == count_ff - 5'd1);
               ch_in        = ch_ff + 5'd1;
               state_in     = (ch_ff == count_ff - 5'd1) ? ST_IDLE : ST_PREP;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         ch_ff        <= 5'd0;
         count_ff     <= 5'd0;
         step_ff      <= 5'd0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         ch_ff        <= ch_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
      end
      chan_ff      <= chan_in;
      dig_ff       <= dig_in;
      trim_ff      <= trim_in;
      maga_ff      <= maga_in;
      magb_ff      <= magb_in;
      neg_ff       <= neg_in;
      quot_ff      <= quot_in;
      rem_ff       <= rem_in;
      out_index_ff <= out_index_in;
      out_value_ff <= out_value_in;
      out_last_ff  <= out_last_in;
   end

`ifndef SYNTHESIS
   a_ch_in_frame: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (ch_ff < count_ff))
      else $error("channel index beyond frame channel count");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= sbd_pkg::MAX_CHANNELS)
      else $error("channel count above maximum");
   a_div_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (step_ff < 5'(sbd_pkg::QUOT_BITS)))
      else $error("divider ran past its step count");
`endif

endmodule

@@ rtl/sbus_frame_decoder_core.sv @@
// Serial-bus frame decoder: register file, byte collector, frame queue and channel mapper.
//
// Usage:
//  req_* carries received serial bytes, one per transfer. Bytes are dropped until the
//  start byte 0x0F; from it on 25 bytes form a frame (the end byte is not checked).
//  rsp_* carries one transfer per mapped channel: index in tdata[4:0], value in
//  tdata[20:5], tlast on the final channel of the frame. channels_used (clamped to 18)
//  sets how many channels are sent; zero sends none.
//  csr_* is an APB port with 64-bit data; register i lies at byte address 8*i.
//  Bytes are taken one per cycle. The collector stalls only on a frame's end byte
//  when both queue entries hold frames still waiting for the mapper.
//  Each channel passes through the mapper steps in turn (operand setup, one multiply, a 25-step
//  one-bit-per-cycle divider, output); a frame is taken from the queue only once the
//  mapper is idle again after the previous frame.
//  A stalled result receiver holds the mapper in its output step; the queue and the
//  collector keep taking bytes until the queue is full.
//  Reset clears the frame position, the queue and the output valid, and loads the
//  register defaults (bounds 1000/2000, all trims zero, 18 channels).
module sbus_frame_decoder_core (
   input  logic        clock,
   input  logic        reset,
   // Byte input
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] rx_byte
   // Channel results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,    // [4:0] channel_index, [20:5] channel_value
   output logic        rsp_tlast,    // last_channel
   // Configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [5:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);

   logic [63:0] trim_low_ff;
   logic [63:0] trim_mid_ff;
   logic [15:0] trim_high_ff;
   logic [11:0] in_min_ff;
   logic [11:0] in_max_ff;
   logic [11:0] out_min_ff;
   logic [11:0] out_max_ff;
   logic [4:0]  ch_used_ff;

   logic                           wr_en;
   sbd_pkg::reg_index_type         reg_sel;
   sbd_pkg::cfg_type               cfg;
   sbd_pkg::queue_status_type      q_status;
   logic                           push;
   logic                           pop;
   logic [sbd_pkg::FRAME_BITS-1:0] wr_frame;
   logic [sbd_pkg::FRAME_BITS-1:0] rd_frame;

   assign csr_pready = 1'b1;
   assign reg_sel    = sbd_pkg::reg_index_type'(csr_paddr[5:3]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         trim_low_ff  <= '0;
         trim_mid_ff  <= '0;
         trim_high_ff <= '0;
         in_min_ff    <= sbd_pkg::IN_MIN_RESET;
         in_max_ff    <= sbd_pkg::IN_MAX_RESET;
         out_min_ff   <= sbd_pkg::OUT_MIN_RESET;
         out_max_ff   <= sbd_pkg::OUT_MAX_RESET;
         ch_used_ff   <= sbd_pkg::CH_USED_RESET;
      end else if (wr_en) begin
         unique case (reg_sel)
            sbd_pkg::REG_TRIM_LOW:  trim_low_ff  <= csr_pwdata;
            sbd_pkg::REG_TRIM_MID:  trim_mid_ff  <= csr_pwdata;
            sbd_pkg::REG_TRIM_HIGH: trim_high_ff <= csr_pwdata[15:0];
            sbd_pkg::REG_IN_MIN:    in_min_ff    <= csr_pwdata[11:0];
            sbd_pkg::REG_IN_MAX:    in_max_ff    <= csr_pwdata[11:0];
            sbd_pkg::REG_OUT_MIN:   out_min_ff   <= csr_pwdata[11:0];
            sbd_pkg::REG_OUT_MAX:   out_max_ff   <= csr_pwdata[11:0];
            sbd_pkg::REG_CH_USED:   ch_used_ff   <= csr_pwdata[4:0];
            default: begin
            end
         endcase
      end
   end

   // Register readback
   always_comb begin
      unique case (reg_sel)
         sbd_pkg::REG_TRIM_LOW:  csr_prdata = trim_low_ff;
         sbd_pkg::REG_TRIM_MID:  csr_prdata = trim_mid_ff;
         sbd_pkg::REG_TRIM_HIGH: csr_prdata = {48'd0, trim_high_ff};
         sbd_pkg::REG_IN_MIN:    csr_prdata = {52'd0, in_min_ff};
         sbd_pkg::REG_IN_MAX:    csr_prdata = {52'd0, in_max_ff};
         sbd_pkg::REG_OUT_MIN:   csr_prdata = {52'd0, out_min_ff};
         sbd_pkg::REG_OUT_MAX:   csr_prdata = {52'd0, out_max_ff};
         sbd_pkg::REG_CH_USED:   csr_prdata = {59'd0, ch_used_ff};
         default:                csr_prdata = 64'd0;
      endcase
   end

   // Mapping configuration bundle
   assign cfg.trims   = {trim_high_ff, trim_mid_ff, trim_low_ff};
   assign cfg.in_min  = in_min_ff;
   assign cfg.in_max  = in_max_ff;
   assign cfg.out_min = out_min_ff;
   assign cfg.out_max = out_max_ff;
   assign cfg.ch_used = ch_used_ff;

   sbd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_status   (q_status),
      .push       (push),
      .frame      (wr_frame)
   );

   sbd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .wr_frame (wr_frame),
      .pop      (pop),
      .rd_frame (rd_frame),
      .status   (q_status)
   );

   sbd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .q_status   (q_status),
      .q_frame    (rd_frame),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the serial-bus frame decoder: byte stream in, mapped channels out.
`timescale 1ns / 1ps

module testbench;

   // One mapped channel as it should leave the block
   typedef struct packed {
      logic [4:0]  index;
      logic [15:0] value;
      logic        last;
   } channel_result_type;

   // One directed frame: optional noise byte, uniform raw value, flag byte, end byte
   typedef struct packed {
      logic [7:0]  lead;
      logic        has_lead;
      logic [10:0] raw;
      logic [7:0]  flags;
      logic [7:0]  tail;
      logic        load_cfg;
      logic [7:0]  trim;
      logic [11:0] in_min;
      logic [11:0] in_max;
      logic [11:0] out_min;
      logic [11:0] out_max;
      logic [4:0]  used;
      logic        typed;
      logic [15:0] value;
   } frame_row_type;

   localparam int ROW_COUNT    = 6;
   localparam int SETTLE_TICKS = 600;
   localparam int HOLD_TICKS   = 3000;

   // Reset defaults first, then full-scale bounds, equal bounds, empty frame,
   // single channel and a clamped count whose quotient wraps past 16 bits
   localparam frame_row_type DIRECTED_ROWS [ROW_COUNT] = '{
      '{8'h00, 1'b1, 11'd1000,  8'h00, 8'h00, 1'b0, 8'h00,
        12'd1000, 12'd2000, 12'd1000, 12'd2000, 5'd18, 1'b1, 16'd1000},
      '{8'hF0, 1'b1, 11'd2047,  8'h03, 8'h00, 1'b1, 8'h7F,
        12'd0,    12'd4095, 12'd0,    12'd4095, 5'd18, 1'b0, 16'd0},
      '{8'h0E, 1'b1, 11'd1234,  8'h01, 8'h55, 1'b1, 8'h11,
        12'd2048, 12'd2048, 12'd1234, 12'd4095, 5'd18, 1'b1, 16'd1234},
      '{8'h00, 1'b0, 11'h2AA,   8'h00, 8'h00, 1'b1, 8'h00,
        12'd1000, 12'd2000, 12'd1000, 12'd2000, 5'd0,  1'b0, 16'd0},
      '{8'h10, 1'b1, 11'h400,   8'h01, 8'h00, 1'b1, 8'h01,
        12'd0,    12'd2047, 12'd4095, 12'd0,    5'd1,  1'b0, 16'd0},
      '{8'h00, 1'b0, 11'd0,     8'h01, 8'hFF, 1'b1, 8'h80,
        12'd4095, 12'd4094, 12'd0,    12'd4095, 5'd31, 1'b0, 16'd0}
   };

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // [7:0] rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;    // [4:0] channel_index, [20:5] channel_value
   logic        rsp_tlast;    // last_channel
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [5:0]  csr_paddr;
   logic [63:0] csr_pwdata;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   // Decoder shadow state and register copies
   logic [7:0]   frame_bytes [24];
   logic [4:0]   frame_pos;
   logic [143:0] trim_bytes;
   logic [11:0]  in_min_reg;
   logic [11:0]  in_max_reg;
   logic [11:0]  out_min_reg;
   logic [11:0]  out_max_reg;
   logic [4:0]   used_reg;

   channel_result_type awaited_channels [$];
   logic               typed_on;
   logic [15:0]        typed_value;
   int                 mismatches;
   logic               steady;
   int                 hold_orders;
   int                 hold_taken;

   sbus_frame_decoder_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard stop if the run hangs
   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

   // Take one byte into the shadow collector and queue the channels a full frame yields
   task automatic absorb_byte(input logic [7:0] rx);
      logic [183:0]        payload;
      logic [4:0]          count;
      longint              x;
      longint              y;
      channel_result_type  item;
      if (frame_pos == 5'd0 && rx != sbd_pkg::START_MARK) return;
      if (frame_pos < 5'd24) frame_bytes[frame_pos] = rx;
      frame_pos = frame_pos + 5'd1;
      if (frame_pos < sbd_pkg::FRAME_LENGTH) return;
      frame_pos = 5'd0;
      for (int k = 1; k < 24; k++) payload[8*(k-1) +: 8] = frame_bytes[k];
      count = (used_reg > sbd_pkg::MAX_CHANNELS) ? sbd_pkg::MAX_CHANNELS : used_reg;
      for (int ch = 0; ch < count; ch++) begin
         if (ch < sbd_pkg::PROP_CHANNELS) begin
            x = longint'(payload[11*ch +: 11]);
         end else begin
            x = payload[176 + ch - sbd_pkg::PROP_CHANNELS] ? longint'(in_max_reg)
                                                           : longint'(in_min_reg);
         end
         x = x + longint'(signed'(trim_bytes[8*ch +: 8]));
         if (in_max_reg == in_min_reg) begin
            y = longint'(out_min_reg);
         end else begin
            y = (x - longint'(in_min_reg)) * (longint'(out_max_reg) - longint'(out_min_reg))
                / (longint'(in_max_reg) - longint'(in_min_reg)) + longint'(out_min_reg);
         end
         item.index = ch[4:0];
         item.value = typed_on ? typed_value : y[15:0];
         item.last  = (ch + 1 == count);
         awaited_channels.push_back(item);
      end
   endtask

   // Compare one delivered channel against the oldest awaited one
   task automatic check_channel(input logic [23:0] data, input logic last);
      channel_result_type want;
      if (awaited_channels.size() == 0) begin
         $error("unexpected channel transfer: index %0d value %0d",
                data[4:0], $signed(data[20:5]));
         mismatches++;
         return;
      end
      want = awaited_channels.pop_front();
      if (data[4:0] != want.index) begin
         $error("channel_index: expected %0d, actual %0d", want.index, data[4:0]);
         mismatches++;
      end
      if (data[20:5] != want.value) begin
         $error("channel_value: expected %0d, actual %0d",
                $signed(want.value), $signed(data[20:5]));
         mismatches++;
      end
      if (last != want.last) begin
         $error("last_channel: expected %0d, actual %0d", want.last, last);
         mismatches++;
      end
   endtask

   // Watch both channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) absorb_byte(req_tdata);
         if (rsp_tvalid && rsp_tready) check_channel(rsp_tdata, rsp_tlast);
      end
   end

   // Result receiver: random stalls, an optional long hold-off
   initial begin
      int hold_left;
      hold_left  = 0;
      hold_taken = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_orders != hold_taken) begin
            hold_taken = hold_orders;
            hold_left  = HOLD_TICKS;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready = 1'b0;
         end else begin
            rsp_tready = steady || ($urandom_range(0, 99) >= 17);
         end
      end
   end

   // Offer one byte, idling at random, and hold it until it is taken
   task automatic send_byte(input logic [7:0] b);
      @(negedge clock);
      while (!steady && $urandom_range(0, 99) < 17) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = b;
      do @(posedge clock); while (!req_tready);
   endtask

   // Send start byte, 23 payload bytes (flags in the top byte) and the end byte
   task automatic send_frame(input logic [183:0] payload, input logic [7:0] tail);
      send_byte(sbd_pkg::START_MARK);
      for (int k = 0; k < 23; k++) send_byte(payload[8*k +: 8]);
      send_byte(tail);
   endtask

   // Drop valid, wait for every awaited channel, then let the mapper settle
   task automatic await_idle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (awaited_channels.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   // Write one register, mirror it, and read it back
   task automatic set_register(input sbd_pkg::reg_index_type idx, input logic [63:0] value);
      logic [63:0] mask;
      logic [63:0] seen;
      case (idx)
         sbd_pkg::REG_TRIM_LOW:  mask = '1;
         sbd_pkg::REG_TRIM_MID:  mask = '1;
         sbd_pkg::REG_TRIM_HIGH: mask = 64'hFFFF;
         sbd_pkg::REG_CH_USED:   mask = 64'h1F;
         default:                mask = 64'hFFF;
      endcase
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {idx, 3'b000};
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         sbd_pkg::REG_TRIM_LOW:  trim_bytes[63:0]    = value;
         sbd_pkg::REG_TRIM_MID:  trim_bytes[127:64]  = value;
         sbd_pkg::REG_TRIM_HIGH: trim_bytes[143:128] = value[15:0];
         sbd_pkg::REG_IN_MIN:    in_min_reg  = value[11:0];
         sbd_pkg::REG_IN_MAX:    in_max_reg  = value[11:0];
         sbd_pkg::REG_OUT_MIN:   out_min_reg = value[11:0];
         sbd_pkg::REG_OUT_MAX:   out_max_reg = value[11:0];
         sbd_pkg::REG_CH_USED:   used_reg    = value[4:0];
         default: ;
      endcase
      @(negedge clock);
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      seen = csr_prdata;
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      if ((seen & mask) != (value & mask)) begin
         $error("register %s readback: expected %h, actual %h",
                idx.name(), value & mask, seen & mask);
         mismatches++;
      end
   endtask

   // Load a full mapping setting
   task automatic load_setting(input logic [63:0] low, input logic [63:0] mid,
                               input logic [15:0] high, input logic [11:0] imin,
                               input logic [11:0] imax, input logic [11:0] omin,
                               input logic [11:0] omax, input logic [4:0] used);
      set_register(sbd_pkg::REG_TRIM_LOW, low);
      set_register(sbd_pkg::REG_TRIM_MID, mid);
      set_register(sbd_pkg::REG_TRIM_HIGH, {48'd0, high});
      set_register(sbd_pkg::REG_IN_MIN, {52'd0, imin});
      set_register(sbd_pkg::REG_IN_MAX, {52'd0, imax});
      set_register(sbd_pkg::REG_OUT_MIN, {52'd0, omin});
      set_register(sbd_pkg::REG_OUT_MAX, {52'd0, omax});
      set_register(sbd_pkg::REG_CH_USED, {59'd0, used});
   endtask

   // Random bound, often at an extreme
   function automatic logic [11:0] pick_bound();
      case ($urandom_range(0, 7))
         0:       return 12'd0;
         1:       return 12'd4095;
         default: return 12'($urandom_range(0, 4095));
      endcase
   endfunction

   initial begin
      frame_row_type row;
      logic [183:0]  payload;
      logic [4:0]    used;
      int            sent;
      int            pick;
      int            cut;

      // Hold every input at a known value and reset the shadow state
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = 8'd0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = 6'd0;
      csr_pwdata  = 64'd0;
      steady      = 1'b0;
      hold_orders = 0;
      mismatches  = 0;
      typed_on    = 1'b0;
      typed_value = 16'd0;
      frame_pos   = 5'd0;
      for (int k = 0; k < 24; k++) frame_bytes[k] = 8'd0;
      trim_bytes  = '0;
      in_min_reg  = sbd_pkg::IN_MIN_RESET;
      in_max_reg  = sbd_pkg::IN_MAX_RESET;
      out_min_reg = sbd_pkg::OUT_MIN_RESET;
      out_max_reg = sbd_pkg::OUT_MAX_RESET;
      used_reg    = sbd_pkg::CH_USED_RESET;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed frames
      for (int r = 0; r < ROW_COUNT; r++) begin
         row = DIRECTED_ROWS[r];
         if (row.load_cfg) begin
            load_setting({8{row.trim}}, {8{row.trim}}, {2{row.trim}}, row.in_min,
                         row.in_max, row.out_min, row.out_max, row.used);
         end
         typed_on    = row.typed;
         typed_value = row.value;
         payload     = {row.flags, {16{row.raw}}};
         if (row.has_lead) send_byte(row.lead);
         send_frame(payload, row.tail);
         await_idle();
         typed_on = 1'b0;
      end

      // Random phases: first a held-off receiver with whole frames, then a mixed stream
      for (int p = 0; p < 2; p++) begin
         if (p == 0) begin
            used = sbd_pkg::MAX_CHANNELS;
         end else begin
            case ($urandom_range(0, 9))
               0:       used = 5'd0;
               1:       used = 5'($urandom_range(19, 31));
               default: used = 5'($urandom_range(1, 18));
            endcase
         end
         load_setting({$urandom, $urandom}, {$urandom, $urandom}, 16'($urandom),
                      pick_bound(), pick_bound(), pick_bound(), pick_bound(), used);
         steady = (p == 0);
         if (p == 0) hold_orders++;
         sent = 0;
         while (sent < ((p == 0) ? 100 : 20)) begin
            pick = (p == 0) ? 0 : $urandom_range(0, 9);
            if (pick < 7) begin
               for (int k = 0; k < 23; k++) payload[8*k +: 8] = 8'($urandom);
               send_frame(payload, 8'($urandom));
               sent += 25;
            end else if (pick == 7) begin
               // noise between frames
               repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
            end else begin
               // cut-off frame that the next bytes run into
               cut = $urandom_range(1, 23);
               send_byte(sbd_pkg::START_MARK);
               repeat (cut) send_byte(8'($urandom));
               sent += cut + 1;
            end
         end
         await_idle();
         steady = 1'b0;
      end

      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
